@@ hw/rtl/rtprl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rtprl_pkg;

	localparam int TABLE_DEPTH_DEF = 128;

	localparam int KEY_W    = 32;
	localparam int IP_W     = 32;
	localparam int PORT_W   = 16;
	localparam int ADDR_W   = IP_W + PORT_W;
	localparam int LEN_W    = 16;
	localparam int CSRC_W   = 4;
	localparam int PEERS_W  = 8;
	localparam int STATUS_W = 3;

	localparam logic [PEERS_W-1:0] MAX_PEERS_RESET = 8'd100;
	localparam logic [LEN_W-1:0]   REPORT_MAX_LEN  = 16'd12;

	localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REPORT    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LEARNED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_ADDR,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

@@ hw/rtl/rtp_relay_learning_table.sv @@
// RTP relay learning table. Each input beat is one parsed RTP header; each
// produces exactly one result beat. Peers are stored in order of arrival in
// two single-port-read RAMs (keys, addresses) and are never removed; a fill
// count marks the used slots, so no clearing pass runs after reset. A learn,
// refresh or full beat scans the key RAM one entry per clock, comparing both
// the sync source and the first contributing id in the same pass, then
// writes back and, on a forward hit, reads the stored address. Such a beat
// passes through the scan, decide, address (only when the forward address
// is read back from the RAM) and finish states; a rejected or report beat
// goes from accept straight to finish, which loads the result once the
// output register is free. The next beat can be accepted in the cycle
// after the result is loaded, so the key RAM scan sets the rate. One beat
// is processed at a time; a finished result waits in the output register
// while the next beat is accepted. The user writes max_peers over the cfg
// channel while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module rtp_relay_learning_table
	import rtprl_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [PEERS_W-1:0]  cfg_data,

	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [KEY_W-1:0]    sync_source,
	input  wire logic [LEN_W-1:0]    pkt_len,
	input  wire logic [CSRC_W-1:0]   csrc_count,
	input  wire logic [KEY_W-1:0]    first_csrc,
	input  wire logic [IP_W-1:0]     src_ip,
	input  wire logic [PORT_W-1:0]   src_port,

	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic                     forward,
	output logic [IP_W-1:0]          dest_ip,
	output logic [PORT_W-1:0]        dest_port
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > PEERS_W) ? CW : PEERS_W;
	localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

	state_t state_q, state_d;

	logic [PEERS_W-1:0]  max_peers_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       issue_q;

	// current beat
	logic [KEY_W-1:0]    sync_q;
	logic [KEY_W-1:0]    csrc_q;
	logic                csrc_nz_q;
	logic [ADDR_W-1:0]   addr_q;

	// scan results
	logic                sync_hit_q, csrc_hit_q;
	logic [AW-1:0]       sync_slot_q, csrc_slot_q;
	logic                rd_valid_s1;
	logic [AW-1:0]       rd_idx_s1;

	logic [STATUS_W-1:0] res_status_q;
	logic                res_fwd_q;
	logic [ADDR_W-1:0]   res_dest_q;

	logic                out_valid_q;

	// RAM ports
	logic                key_we, addr_we;
	logic [AW-1:0]       addr_waddr;
	logic [KEY_W-1:0]    key_rdata;
	logic [ADDR_W-1:0]   addr_rdata;

	logic                issue;
	logic                room;
	logic [LW-1:0]       peers_l, limit_l;
	logic                fwd_self;
	logic                out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	assign peers_l  = LW'(max_peers_q);
	assign limit_l  = (peers_l > DEPTH_L) ? DEPTH_L : peers_l;
	assign room     = LW'(count_q) < limit_l;
	assign issue    = (state_q == S_SCAN) && (issue_q != count_q);
	assign fwd_self = csrc_nz_q && (csrc_q == sync_q) && (sync_hit_q || room);

	assign key_we     = (state_q == S_DECIDE) && !sync_hit_q && room;
	assign addr_we    = (state_q == S_DECIDE) && (sync_hit_q || room);
	assign addr_waddr = sync_hit_q ? sync_slot_q : count_q[AW-1:0];

	rtprl_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (count_q[AW-1:0]),
		.wdata (sync_q),
		.raddr (issue_q[AW-1:0]),
		.rdata (key_rdata)
	);

	rtprl_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_addr_ram (
		.clk   (clk),
		.we    (addr_we),
		.waddr (addr_waddr),
		.wdata (addr_q),
		.raddr (csrc_slot_q),
		.rdata (addr_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (sync_source == '0 || pkt_len <= REPORT_MAX_LEN) ?
						S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				if (!issue && !rd_valid_s1) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!fwd_self && csrc_nz_q && csrc_hit_q) begin
					state_d = S_ADDR;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_ADDR: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_peers_q <= MAX_PEERS_RESET;
			count_q     <= '0;
			issue_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				max_peers_q <= cfg_data;
			end
			if (key_we) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_IDLE) begin
				issue_q <= '0;
			end else if (issue) begin
				issue_q <= issue_q + 1'b1;
			end
			rd_valid_s1 <= issue;
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// beat payload and scan bookkeeping
	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				sync_q      <= sync_source;
				csrc_q      <= first_csrc;
				csrc_nz_q   <= (csrc_count != '0);
				addr_q      <= {src_ip, src_port};
				sync_hit_q  <= 1'b0;
				csrc_hit_q  <= 1'b0;
				res_fwd_q   <= 1'b0;
				res_dest_q  <= '0;
				res_status_q <= (sync_source == '0) ? ST_REJECTED : ST_REPORT;
			end
			S_SCAN: begin
				if (rd_valid_s1 && key_rdata == sync_q) begin
					sync_hit_q  <= 1'b1;
					sync_slot_q <= rd_idx_s1;
				end
				if (rd_valid_s1 && key_rdata == csrc_q) begin
					csrc_hit_q  <= 1'b1;
					csrc_slot_q <= rd_idx_s1;
				end
			end
			S_DECIDE: begin
				if (sync_hit_q) begin
					res_status_q <= ST_REFRESHED;
				end else if (room) begin
					res_status_q <= ST_LEARNED;
				end else begin
					res_status_q <= ST_FULL;
				end
				if (fwd_self) begin
					res_fwd_q  <= 1'b1;
					res_dest_q <= addr_q;
				end
			end
			S_ADDR: begin
				res_fwd_q  <= 1'b1;
				res_dest_q <= addr_rdata;
			end
			S_FINISH: begin
				if (out_free) begin
					status    <= res_status_q;
					forward   <= res_fwd_q;
					dest_ip   <= res_dest_q[ADDR_W-1:PORT_W];
					dest_port <= res_dest_q[PORT_W-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/rtprl_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtprl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import rtprl_pkg::*;

	localparam int TB_DEPTH    = TABLE_DEPTH_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int POOL_SIZE   = 192;
	localparam int MAX_PRINTS  = 100;

	typedef struct packed {
		logic [KEY_W-1:0]  sync_source;
		logic [LEN_W-1:0]  pkt_len;
		logic [CSRC_W-1:0] csrc_count;
		logic [KEY_W-1:0]  first_csrc;
		logic [IP_W-1:0]   src_ip;
		logic [PORT_W-1:0] src_port;
	} rtp_hdr_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                forward;
		logic [IP_W-1:0]     dest_ip;
		logic [PORT_W-1:0]   dest_port;
	} relay_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [PEERS_W-1:0]  cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [KEY_W-1:0]    sync_source;
	logic [LEN_W-1:0]    pkt_len;
	logic [CSRC_W-1:0]   csrc_count;
	logic [KEY_W-1:0]    first_csrc;
	logic [IP_W-1:0]     src_ip;
	logic [PORT_W-1:0]   src_port;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic                forward;
	logic [IP_W-1:0]     dest_ip;
	logic [PORT_W-1:0]   dest_port;

	// predictor copy of the peer table
	logic                peer_valid [TB_DEPTH];
	logic [KEY_W-1:0]    peer_key   [TB_DEPTH];
	logic [ADDR_W-1:0]   peer_addr  [TB_DEPTH];
	int                  peer_fill;
	logic [PEERS_W-1:0]  peer_limit;

	relay_result_t       expected_q [$];
	logic [KEY_W-1:0]    key_pool   [POOL_SIZE];
	int                  error_count;
	int                  quiet_cycles;
	int                  send_calm;
	int                  recv_calm;

	rtp_relay_learning_table #(
		.TABLE_DEPTH(TB_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sync_source(sync_source),
		.pkt_len(pkt_len),
		.csrc_count(csrc_count),
		.first_csrc(first_csrc),
		.src_ip(src_ip),
		.src_port(src_port),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.forward(forward),
		.dest_ip(dest_ip),
		.dest_port(dest_port)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int find_peer(logic [KEY_W-1:0] key);
		for (int i = 0; i < TB_DEPTH; i++) begin
			if (peer_valid[i] && peer_key[i] == key)
				return i;
		end
		return -1;
	endfunction

	// learn/refresh first, then the forward lookup sees the updated table
	function automatic relay_result_t predict_relay(rtp_hdr_t h);
		relay_result_t r;
		int slot;
		int cap;
		r = '0;
		if (h.sync_source == '0) begin
			r.status = ST_REJECTED;
		end else if (h.pkt_len <= REPORT_MAX_LEN) begin
			r.status = ST_REPORT;
		end else begin
			slot = find_peer(h.sync_source);
			if (slot >= 0) begin
				peer_addr[slot] = {h.src_ip, h.src_port};
				r.status = ST_REFRESHED;
			end else begin
				cap = int'(peer_limit);
				if (cap > TB_DEPTH)
					cap = TB_DEPTH;
				if (peer_fill < cap) begin
					peer_valid[peer_fill] = 1'b1;
					peer_key[peer_fill]   = h.sync_source;
					peer_addr[peer_fill]  = {h.src_ip, h.src_port};
					peer_fill++;
					r.status = ST_LEARNED;
				end else begin
					r.status = ST_FULL;
				end
			end
			if (h.csrc_count != '0) begin
				slot = find_peer(h.first_csrc);
				if (slot >= 0) begin
					r.forward   = 1'b1;
					r.dest_ip   = peer_addr[slot][ADDR_W-1:PORT_W];
					r.dest_port = peer_addr[slot][PORT_W-1:0];
				end
			end
		end
		return r;
	endfunction

	// random wait, with occasional stretches of back-to-back beats
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 17);
	endfunction

	function automatic rtp_hdr_t mk_hdr(logic [KEY_W-1:0] ssrc, logic [LEN_W-1:0] len,
			logic [CSRC_W-1:0] cc, logic [KEY_W-1:0] dst, logic [IP_W-1:0] ip,
			logic [PORT_W-1:0] port);
		rtp_hdr_t h;
		h.sync_source = ssrc;
		h.pkt_len     = len;
		h.csrc_count  = cc;
		h.first_csrc  = dst;
		h.src_ip      = ip;
		h.src_port    = port;
		return h;
	endfunction

	function automatic rtp_hdr_t random_hdr(int span);
		rtp_hdr_t h;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 3)
			h.sync_source = '0;
		else if (sel < 88)
			h.sync_source = key_pool[$urandom_range(0, span - 1)];
		else
			h.sync_source = $urandom;
		sel = $urandom_range(0, 99);
		if (sel < 12)
			h.pkt_len = LEN_W'($urandom_range(0, 12));
		else if (sel < 16)
			h.pkt_len = 16'd13;
		else
			h.pkt_len = LEN_W'($urandom_range(13, 65535));
		h.csrc_count = ($urandom_range(0, 4) == 0) ? '0 : CSRC_W'($urandom_range(1, 15));
		sel = $urandom_range(0, 99);
		if (sel < 65)
			h.first_csrc = key_pool[$urandom_range(0, span - 1)];
		else if (sel < 75)
			h.first_csrc = '0;
		else if (sel < 88)
			h.first_csrc = h.sync_source;
		else
			h.first_csrc = $urandom;
		h.src_ip   = $urandom;
		h.src_port = PORT_W'($urandom_range(0, 65535));
		return h;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	task automatic send_packet(rtp_hdr_t h);
		int gap;
		gap = draw_gap(send_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sync_source <= h.sync_source;
		pkt_len     <= h.pkt_len;
		csrc_count  <= h.csrc_count;
		first_csrc  <= h.first_csrc;
		src_ip      <= h.src_ip;
		src_port    <= h.src_port;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(predict_relay(h));
	endtask

	// every beat gives one result, so an empty queue means the block is idle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_peers(logic [PEERS_W-1:0] value);
		@(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		peer_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(logic [PEERS_W-1:0] limit, int span, int count);
		write_max_peers(limit);
		repeat (count) send_packet(random_hdr(span));
		wait_idle();
	endtask

	task automatic test_reject_and_report();
		send_packet(mk_hdr('0, '1, '1, 32'h1111_0001, '1, '1));
		send_packet(mk_hdr(32'h1111_0001, 16'd0, 4'd1, 32'h1111_0001, 32'h0a00_0001, 16'd5004));
		send_packet(mk_hdr('1, 16'd12, 4'd15, '1, '1, '1));
		wait_idle();
	endtask

	task automatic test_full_at_zero_limit();
		write_max_peers(8'd0);
		// refused, lookup still runs and misses
		send_packet(mk_hdr(32'h1111_0001, 16'd13, 4'd1, 32'h1111_0001, 32'h0a00_0001,
			16'd5004));
		wait_idle();
	endtask

	task automatic test_learn_refresh_forward();
		write_max_peers(8'd2);
		send_packet(mk_hdr(32'h1111_0001, 16'd13, 4'd0, '0, 32'h0a00_0001, 16'd5004));
		send_packet(mk_hdr('1, '1, 4'd15, 32'h1111_0001, '1, '1));
		// table full, forward lookup still hits
		send_packet(mk_hdr(32'h2222_0002, 16'd200, 4'd1, '1, 32'hc0a8_0101, 16'd7000));
		// same address again
		send_packet(mk_hdr(32'h1111_0001, 16'd13, 4'd0, '0, 32'h0a00_0001, 16'd5004));
		// new address, forward to self sees it
		send_packet(mk_hdr(32'h1111_0001, 16'd1500, 4'd2, 32'h1111_0001, 32'h0a00_0063,
			16'd6000));
		send_packet(mk_hdr('1, 16'd400, 4'd3, '0, 32'h5555_aaaa, 16'h5a5a));
		// report does not touch the stored address
		send_packet(mk_hdr(32'h1111_0001, 16'd12, 4'd1, '1, 32'hdead_beef, 16'hbeef));
		send_packet(mk_hdr('1, 16'd13, 4'd1, 32'h1111_0001, 32'h5555_aaaa, 16'h5a5a));
		send_packet(mk_hdr('1, 16'd13, 4'd0, '0, '0, '0));
		send_packet(mk_hdr(32'h1111_0001, 16'd13, 4'd8, '1, 32'haaaa_5555, 16'ha5a5));
		wait_idle();
	endtask

	task automatic test_limit_below_count();
		write_max_peers(8'd1);
		send_packet(mk_hdr(32'h3333_0003, 16'd13, 4'd1, 32'h3333_0003, 32'h0102_0304,
			16'd1));
		send_packet(mk_hdr('1, 16'd13, 4'd1, '1, 32'h0102_0305, 16'd2));
		wait_idle();
	endtask

	task automatic test_random_small_limit();
		run_random(8'd20, 30, 300);
	endtask

	task automatic test_random_reset_limit();
		run_random(MAX_PEERS_RESET, 120, 350);
	endtask

	task automatic test_random_limit_above_depth();
		run_random(8'd255, POOL_SIZE, 400);
	endtask

	task automatic test_random_limit_at_depth();
		run_random(8'd128, POOL_SIZE, 280);
	endtask

	task automatic finish_run();
		wait_idle();
		repeat (150) @(posedge clk);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	endtask

	// result side: random back-pressure
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(recv_calm);
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		relay_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with none expected", 32'(status), 32'd0);
			end else begin
				want = expected_q.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (forward !== want.forward)
					report_mismatch("forward", 32'(forward), 32'(want.forward));
				if (dest_ip !== want.dest_ip)
					report_mismatch("dest_ip", dest_ip, want.dest_ip);
				if (dest_port !== want.dest_port)
					report_mismatch("dest_port", 32'(dest_port), 32'(want.dest_port));
			end
		end
	end

	// watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [KEY_W-1:0] k;
		logic dup;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		sync_source = '0;
		pkt_len     = '0;
		csrc_count  = '0;
		first_csrc  = '0;
		src_ip      = '0;
		src_port    = '0;
		send_calm    = 0;
		peer_fill    = 0;
		peer_limit   = MAX_PEERS_RESET;
		for (int i = 0; i < TB_DEPTH; i++) begin
			peer_valid[i] = 1'b0;
			peer_key[i]   = '0;
			peer_addr[i]  = '0;
		end
		// distinct nonzero source ids, extremes first
		key_pool[0] = '1;
		key_pool[1] = 32'd1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			do begin
				k = $urandom;
				dup = (k == '0);
				for (int j = 0; j < i; j++)
					if (key_pool[j] == k)
						dup = 1'b1;
			end while (dup);
			key_pool[i] = k;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reject_and_report();
		test_full_at_zero_limit();
		test_learn_refresh_forward();
		test_limit_below_count();
		test_random_small_limit();
		test_random_reset_limit();
		test_random_limit_above_depth();
		test_random_limit_at_depth();
		finish_run();
	end

endmodule
